### sv/ramr_pkg.sv
// Package with command codes, result widths and saturation limits of the rational unit.
`timescale 1ns / 1ps

package ramr_pkg;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_NORM = 2'd0;
    localparam t_cmd CMD_ADD  = 2'd1;
    localparam t_cmd CMD_MUL  = 2'd2;

    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 30;
    localparam int LIMIT_W   = 33;

    typedef logic [LIMIT_W-1:0] t_limit;

    localparam t_limit NUM_POS_MAX = 33'h0_7FFF_FFFF;
    localparam t_limit NUM_NEG_MAX = 33'h0_8000_0000;
    localparam t_limit DEN_MAX     = 33'h0_3FFF_FFFF;

endpackage

### sv/rational_add_multiply_reduce_unit.sv
// Rational normalize, add and multiply unit with iterative gcd reduction.
// One item is in work at a time; W = 2*OPERAND_BITS + 1 is the working width.
// The reduction uses binary gcd steps.
// The two divisions by the gcd run one quotient bit per cycle on the same adder.
// The next transfer is accepted in the cycle after the result is loaded into the output register.
// Reset is synchronous and active low and returns the sequencer to idle with no result pending.
`timescale 1ns / 1ps

module rational_add_multiply_reduce_unit #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_cmd,
    input  logic signed [OPERAND_BITS-1:0]        i_a_num,
    input  logic signed [OPERAND_BITS-1:0]        i_a_den,
    input  logic signed [OPERAND_BITS-1:0]        i_b_num,
    input  logic signed [OPERAND_BITS-1:0]        i_b_den,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ramr_pkg::RES_NUM_W-1:0] o_res_num,
    output logic [ramr_pkg::RES_DEN_W-1:0]        o_res_den,
    output logic                                  o_zero_den
);

    localparam int OB = OPERAND_BITS;
    localparam int PW = 2 * OB;
    localparam int W  = PW + 1;
    localparam int UW = W + 1;
    localparam int MW = (W > ramr_pkg::LIMIT_W) ? W : ramr_pkg::LIMIT_W;
    localparam int CW = $clog2(W);
    localparam int KW = $clog2(W + 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_FIX  = 4'd5;
    localparam logic [3:0] S_NORM = 4'd6;
    localparam logic [3:0] S_GCD  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]            r_state, n_state;
    ramr_pkg::t_cmd        r_cmd, n_cmd;
    logic [OB-1:0]         r_am, n_am, r_adm, n_adm, r_bm, n_bm, r_bdm, n_bdm;
    logic                  r_nneg, n_nneg, r_n2, n_n2, r_dneg, n_dneg, r_flag, n_flag;
    logic [W-1:0]          r_x, n_x, r_y, n_y, r_t, n_t, r_u, n_u, r_v, n_v, r_g, n_g;
    logic [W-1:0]          r_quo, n_quo, r_rem, n_rem;
    logic [KW-1:0]         r_k, n_k;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_sel, n_sel;
    logic                  r_out_valid, n_out_valid;
    logic [ramr_pkg::RES_NUM_W-1:0] r_res_num, n_res_num;
    logic [ramr_pkg::RES_DEN_W-1:0] r_res_den, n_res_den;
    logic                  r_zero_den, n_zero_den;

    logic [OB-1:0]         w_am, w_adm, w_bm, w_bdm;
    logic [OB-1:0]         w_mul_a, w_mul_b;
    logic [PW-1:0]         w_prod;
    logic [UW-1:0]         w_ua, w_ub;
    logic                  w_usub;
    logic [UW:0]           w_usum;
    logic                  w_carry;
    logic [UW-1:0]         w_trial;
    logic [W-1:0]          w_qnext;
    logic [MW-1:0]         w_nm, w_dm, w_nlim, w_ncl, w_dlim, w_dcl;
    logic                  w_load;

    assign w_am  = i_a_num[OB-1] ? OB'(~$unsigned(i_a_num) + 1'b1) : $unsigned(i_a_num);
    assign w_adm = i_a_den[OB-1] ? OB'(~$unsigned(i_a_den) + 1'b1) : $unsigned(i_a_den);
    assign w_bm  = i_b_num[OB-1] ? OB'(~$unsigned(i_b_num) + 1'b1) : $unsigned(i_b_num);
    assign w_bdm = i_b_den[OB-1] ? OB'(~$unsigned(i_b_den) + 1'b1) : $unsigned(i_b_den);

    // Single multiplier, operands chosen by the sequencer.
    always_comb begin
        case (r_state)
            S_MUL0: begin
                w_mul_a = r_am;
                w_mul_b = (r_cmd == ramr_pkg::CMD_ADD) ? r_bdm : r_bm;
            end
            S_MUL1: begin
                w_mul_a = r_bm;
                w_mul_b = r_adm;
            end
            default: begin
                w_mul_a = r_adm;
                w_mul_b = r_bdm;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Single add/subtract unit shared by the sum, sign fix, gcd and division steps.
    assign w_trial = {r_rem, r_quo[W-1]};

    always_comb begin
        case (r_state)
            S_SUM: begin
                w_ua   = {1'b0, r_t};
                w_ub   = {1'b0, r_x};
                w_usub = (r_nneg != r_n2);
            end
            S_FIX: begin
                w_ua   = '0;
                w_ub   = {1'b0, r_x};
                w_usub = 1'b1;
            end
            S_GCD: begin
                w_ua   = {1'b0, r_u};
                w_ub   = {1'b0, r_v};
                w_usub = 1'b1;
            end
            S_DIV: begin
                w_ua   = w_trial;
                w_ub   = {1'b0, r_g};
                w_usub = 1'b1;
            end
            default: begin
                w_ua   = '0;
                w_ub   = '0;
                w_usub = 1'b0;
            end
        endcase
    end

    assign w_usum  = {1'b0, w_ua} + {1'b0, (w_usub ? ~w_ub : w_ub)} + {{UW{1'b0}}, w_usub};
    assign w_carry = w_usum[UW];
    assign w_qnext = {r_quo[W-2:0], w_carry};

    // Saturation of the reduced pair into the result fields.
    assign w_nm   = MW'(r_x);
    assign w_dm   = MW'(r_y);
    assign w_nlim = r_nneg ? MW'(ramr_pkg::NUM_NEG_MAX) : MW'(ramr_pkg::NUM_POS_MAX);
    assign w_ncl  = (w_nm > w_nlim) ? w_nlim : w_nm;
    assign w_dlim = MW'(ramr_pkg::DEN_MAX);
    assign w_dcl  = (w_dm > w_dlim) ? w_dlim : w_dm;

    assign w_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_am        = r_am;
        n_adm       = r_adm;
        n_bm        = r_bm;
        n_bdm       = r_bdm;
        n_nneg      = r_nneg;
        n_n2        = r_n2;
        n_dneg      = r_dneg;
        n_flag      = r_flag;
        n_x         = r_x;
        n_y         = r_y;
        n_t         = r_t;
        n_u         = r_u;
        n_v         = r_v;
        n_g         = r_g;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_sel       = r_sel;
        n_res_num   = r_res_num;
        n_res_den   = r_res_den;
        n_zero_den  = r_zero_den;
        n_out_valid = w_load | (r_out_valid & ~i_out_ready);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd  = i_cmd;
                    n_am   = w_am;
                    n_adm  = w_adm;
                    n_bm   = w_bm;
                    n_bdm  = w_bdm;
                    n_flag = 1'b0;
                    case (i_cmd)
                        ramr_pkg::CMD_ADD: begin
                            n_nneg  = i_a_num[OB-1] ^ i_b_den[OB-1];
                            n_n2    = i_b_num[OB-1] ^ i_a_den[OB-1];
                            n_dneg  = i_a_den[OB-1] ^ i_b_den[OB-1];
                            n_state = S_MUL0;
                        end
                        ramr_pkg::CMD_MUL: begin
                            n_nneg  = i_a_num[OB-1] ^ i_b_num[OB-1];
                            n_dneg  = i_a_den[OB-1] ^ i_b_den[OB-1];
                            n_state = S_MUL0;
                        end
                        default: begin
                            n_nneg  = i_a_num[OB-1];
                            n_dneg  = i_a_den[OB-1];
                            n_x     = W'(w_am);
                            n_y     = W'(w_adm);
                            n_state = S_NORM;
                        end
                    endcase
                end
            end
            S_MUL0: begin
                if (r_cmd == ramr_pkg::CMD_ADD) begin
                    n_t     = W'(w_prod);
                    n_state = S_MUL1;
                end else begin
                    n_x     = W'(w_prod);
                    n_state = S_MUL2;
                end
            end
            S_MUL1: begin
                n_x     = W'(w_prod);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_y     = W'(w_prod);
                n_state = (r_cmd == ramr_pkg::CMD_ADD) ? S_SUM : S_NORM;
            end
            S_SUM: begin
                n_x = w_usum[W-1:0];
                if (w_usub && !w_carry) begin
                    n_nneg  = r_n2;
                    n_state = S_FIX;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_FIX: begin
                n_x     = w_usum[W-1:0];
                n_state = S_NORM;
            end
            S_NORM: begin
                n_nneg = (r_x != '0) && (r_nneg ^ (r_dneg && (r_y != '0)));
                n_u    = r_x;
                n_k    = '0;
                if (r_y == '0) begin
                    n_flag = 1'b1;
                    n_y    = W'(1);
                    n_v    = W'(1);
                end else begin
                    n_v    = r_y;
                end
                n_state = S_GCD;
            end
            S_GCD: begin
                if (r_u == '0) begin
                    n_g     = r_v << r_k;
                    n_quo   = r_x;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_sel   = 1'b0;
                    n_state = S_DIV;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (w_carry) begin
                    n_u = w_usum[W-1:0] >> 1;
                end else begin
                    n_u = r_v;
                    n_v = r_u;
                end
            end
            S_DIV: begin
                n_rem = w_carry ? w_usum[W-1:0] : w_trial[W-1:0];
                n_quo = w_qnext;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    if (!r_sel) begin
                        n_x   = w_qnext;
                        n_quo = r_y;
                        n_rem = '0;
                        n_cnt = '0;
                        n_sel = 1'b1;
                    end else begin
                        n_y     = w_qnext;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_res_num  = r_nneg ? (ramr_pkg::RES_NUM_W'(0) - w_ncl[ramr_pkg::RES_NUM_W-1:0])
                                        : w_ncl[ramr_pkg::RES_NUM_W-1:0];
                    n_res_den  = w_dcl[ramr_pkg::RES_DEN_W-1:0];
                    n_zero_den = r_flag;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_am       <= n_am;
        r_adm      <= n_adm;
        r_bm       <= n_bm;
        r_bdm      <= n_bdm;
        r_nneg     <= n_nneg;
        r_n2       <= n_n2;
        r_dneg     <= n_dneg;
        r_flag     <= n_flag;
        r_x        <= n_x;
        r_y        <= n_y;
        r_t        <= n_t;
        r_u        <= n_u;
        r_v        <= n_v;
        r_g        <= n_g;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_sel      <= n_sel;
        r_res_num  <= n_res_num;
        r_res_den  <= n_res_den;
        r_zero_den <= n_zero_den;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_res_num   = $signed(r_res_num);
    assign o_res_den   = r_res_den;
    assign o_zero_den  = r_zero_den;

endmodule

### tb/rational_add_multiply_reduce_unit_tb.sv
// Self-checking testbench for the rational normalize, add and multiply unit.
`timescale 1ns / 1ps

module rational_add_multiply_reduce_unit_tb;

    localparam int OPB = 16;
    localparam ramr_pkg::t_cmd CMD_SPARE = 2'd3;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int RANDOM_PHASES = 5;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_in_valid;
    logic                                  o_in_ready;
    logic [1:0]                            i_cmd;
    logic signed [OPB-1:0]                 i_a_num;
    logic signed [OPB-1:0]                 i_a_den;
    logic signed [OPB-1:0]                 i_b_num;
    logic signed [OPB-1:0]                 i_b_den;
    logic                                  o_out_valid;
    logic                                  i_out_ready;
    logic signed [ramr_pkg::RES_NUM_W-1:0] o_res_num;
    logic [ramr_pkg::RES_DEN_W-1:0]        o_res_den;
    logic                                  o_zero_den;

    bit no_gaps;
    int cmd_count [4];

    typedef struct {
        logic signed [ramr_pkg::RES_NUM_W-1:0] num;
        logic [ramr_pkg::RES_DEN_W-1:0]        den;
        logic                                  zero_den;
    } t_fraction;

    class fraction_scoreboard;
        t_fraction due[$];
        int checked = 0;
        int errors = 0;
        int zero_den_seen = 0;

        function void split_operand(input logic [OPB-1:0] v, output bit neg,
                                    output longint unsigned mag);
            logic [OPB-1:0] pos;
            neg = v[OPB-1];
            pos = neg ? -v : v;
            mag = 64'(pos);
        endfunction

        function void note_operands(ramr_pkg::t_cmd cmd, logic [OPB-1:0] an,
                                    logic [OPB-1:0] ad, logic [OPB-1:0] bn,
                                    logic [OPB-1:0] bd);
            bit a_s, ad_s, b_s, bd_s, p_s, q_s, n_s, d_s;
            longint unsigned a_m, ad_m, b_m, bd_m, p_m, q_m, n_m, d_m, x, y, t;
            logic [ramr_pkg::RES_NUM_W-1:0] r;
            t_fraction f;
            split_operand(an, a_s, a_m);
            split_operand(ad, ad_s, ad_m);
            split_operand(bn, b_s, b_m);
            split_operand(bd, bd_s, bd_m);
            f.zero_den = 1'b0;
            case (cmd)
                ramr_pkg::CMD_ADD: begin
                    p_s = a_s ^ bd_s;
                    p_m = a_m * bd_m;
                    q_s = b_s ^ ad_s;
                    q_m = b_m * ad_m;
                    if (p_s == q_s) begin
                        n_s = p_s;
                        n_m = p_m + q_m;
                    end else if (p_m >= q_m) begin
                        n_s = p_s;
                        n_m = p_m - q_m;
                    end else begin
                        n_s = q_s;
                        n_m = q_m - p_m;
                    end
                    d_s = ad_s ^ bd_s;
                    d_m = ad_m * bd_m;
                end
                ramr_pkg::CMD_MUL: begin
                    n_s = a_s ^ b_s;
                    n_m = a_m * b_m;
                    d_s = ad_s ^ bd_s;
                    d_m = ad_m * bd_m;
                end
                default: begin
                    n_s = a_s;
                    n_m = a_m;
                    d_s = ad_s;
                    d_m = ad_m;
                end
            endcase
            if (n_m == 0) n_s = 1'b0;
            if (d_m == 0) begin
                f.zero_den = 1'b1;
                d_m = 1;
            end else if (d_s && n_m != 0) begin
                n_s = !n_s;
            end
            x = n_m;
            y = d_m;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            n_m = n_m / x;
            d_m = d_m / x;
            if (n_s) begin
                if (n_m > ramr_pkg::NUM_NEG_MAX) n_m = 64'(ramr_pkg::NUM_NEG_MAX);
            end else if (n_m > ramr_pkg::NUM_POS_MAX) begin
                n_m = 64'(ramr_pkg::NUM_POS_MAX);
            end
            if (d_m > ramr_pkg::DEN_MAX) d_m = 64'(ramr_pkg::DEN_MAX);
            r = n_m[ramr_pkg::RES_NUM_W-1:0];
            if (n_s) r = -r;
            f.num = r;
            f.den = d_m[ramr_pkg::RES_DEN_W-1:0];
            due.push_back(f);
        endfunction

        function void check_fraction(logic signed [ramr_pkg::RES_NUM_W-1:0] num,
                                     logic [ramr_pkg::RES_DEN_W-1:0] den, logic zd);
            t_fraction f;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: result %0d/%0d zero_den %0b arrived with nothing expected",
                         $time, num, den, zd);
                return;
            end
            f = due.pop_front();
            checked++;
            if (zd === 1'b1) zero_den_seen++;
            if (num !== f.num) begin
                errors++;
                $display("%0t: res_num expected %0d, actual %0d", $time, f.num, num);
            end
            if (den !== f.den) begin
                errors++;
                $display("%0t: res_den expected %0d, actual %0d", $time, f.den, den);
            end
            if (zd !== f.zero_den) begin
                errors++;
                $display("%0t: zero_den expected %0b, actual %0b", $time, f.zero_den, zd);
            end
        endfunction

        function void report_leftover();
            if (due.size() != 0) begin
                errors += due.size();
                $display("%0t: %0d expected results never arrived", $time, due.size());
            end
        endfunction
    endclass

    fraction_scoreboard sb;

    rational_add_multiply_reduce_unit #(
        .OPERAND_BITS(OPB)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_zero_den (o_zero_den)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    function automatic logic [OPB-1:0] pick_operand();
        logic [OPB-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = {1'b1, {(OPB-1){1'b0}}};
                    1: v = {1'b0, {(OPB-1){1'b1}}};
                    2: v = '1;
                    default: v = {1'b1, {(OPB-2){1'b0}}, 1'b1};
                endcase
            end
            1, 2, 3: begin
                v = OPB'($urandom_range(0, 24));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = OPB'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_item(ramr_pkg::t_cmd c, logic [OPB-1:0] an, logic [OPB-1:0] ad,
                             logic [OPB-1:0] bn, logic [OPB-1:0] bd);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd      <= c;
        i_a_num    <= an;
        i_a_den    <= ad;
        i_b_num    <= bn;
        i_b_den    <= bd;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_operands(c, an, ad, bn, bd);
        cmd_count[c]++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_fraction(o_res_num, o_res_den, o_zero_den);
    end

    initial begin
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (no_gaps) begin
                i_out_ready <= 1'b1;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d results still expected.", sb.due.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        sb = new();
        no_gaps    = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_cmd      = ramr_pkg::CMD_NORM;
        i_a_num    = '0;
        i_a_den    = '0;
        i_b_num    = '0;
        i_b_den    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_item(ramr_pkg::CMD_NORM, 0, 5, 0, 0);
        push_item(ramr_pkg::CMD_NORM, 6, 0, 0, 0);
        push_item(ramr_pkg::CMD_NORM, 6, -4, 0, 0);
        push_item(ramr_pkg::CMD_NORM, -32768, -32768, 0, 0);
        push_item(ramr_pkg::CMD_NORM, 32767, -1, 0, 0);
        push_item(ramr_pkg::CMD_NORM, 0, -7, 0, 0);
        push_item(ramr_pkg::CMD_NORM, -32768, 0, 0, 0);
        push_item(ramr_pkg::CMD_NORM, -9, 12, -32768, 32767);
        push_item(CMD_SPARE, 10, -15, 123, -456);
        push_item(ramr_pkg::CMD_ADD, 1, 2, 1, 3);
        push_item(ramr_pkg::CMD_ADD, 1, 2, -1, 2);
        push_item(ramr_pkg::CMD_ADD, 3, 0, 5, 7);
        push_item(ramr_pkg::CMD_ADD, 3, 0, 5, 0);
        push_item(ramr_pkg::CMD_ADD, -32768, -32768, 32767, 32767);
        push_item(ramr_pkg::CMD_ADD, -32768, 32767, 32767, -32765);
        push_item(ramr_pkg::CMD_ADD, 32767, -1, 32767, -1);
        push_item(ramr_pkg::CMD_MUL, 0, 5, 7, 9);
        push_item(ramr_pkg::CMD_MUL, 1, -32768, 1, -32768);
        push_item(ramr_pkg::CMD_MUL, -32768, 1, -32768, 1);
        push_item(ramr_pkg::CMD_MUL, 32767, -32768, -32768, 32767);
        push_item(ramr_pkg::CMD_MUL, 7, 0, 0, 0);
        push_item(ramr_pkg::CMD_MUL, -32767, 32765, 32767, -32763);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            no_gaps = (phase == 2);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                push_item(ramr_pkg::t_cmd'($urandom_range(0, 3)), pick_operand(),
                          pick_operand(), pick_operand(), pick_operand());
            if (phase == 1 || phase == 3) wait_drained();
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (250) @(posedge i_clk);
        sb.report_leftover();

        $display("Sent %0d operand sets: %0d normalize, %0d add, %0d multiply, %0d spare code.",
                 cmd_count[ramr_pkg::CMD_NORM] + cmd_count[ramr_pkg::CMD_ADD] +
                 cmd_count[ramr_pkg::CMD_MUL] + cmd_count[CMD_SPARE],
                 cmd_count[ramr_pkg::CMD_NORM], cmd_count[ramr_pkg::CMD_ADD],
                 cmd_count[ramr_pkg::CMD_MUL], cmd_count[CMD_SPARE]);
        $display("Checked %0d results, %0d of them with a forced denominator, %0d errors.",
                 sb.checked, sb.zero_den_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
